@@ sv/ecm_pkg.sv @@
// ----------------------------------------------------------------------------
// ECM scalar multiply package
// Shared types, constants and the datapath command set.
// ----------------------------------------------------------------------------
package ecm_pkg;

    localparam int unsigned WidthDefault = 64;
    localparam int unsigned RegIdxW      = 1;

    localparam logic [RegIdxW-1:0] RegModulus = 1'b0;
    localparam logic [RegIdxW-1:0] RegCurveA  = 1'b1;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,      // latch inputs
        OP_RED_X,     // reduce base x
        OP_RED_Y,     // reduce base y
        OP_RED_A,     // reduce a
        OP_SETUP_ADD, // P=acc, Q=base
        OP_SETUP_DBL, // P=base, Q=base
        OP_GCD_DX,    // start gcd on x1-x2
        OP_GCD_SY,    // start gcd on y1+y2
        OP_GCD_STEP,  // issued while the gcd runs; no datapath action
        OP_MUL_NUM,   // lam = (y1-y2)*inv
        OP_MUL_XX,    // t = x1*x1
        OP_MUL_TAN,   // lam = (3t+a)*inv
        OP_MUL_LL,    // t = lam*lam
        OP_X3,        // x3 = t - x1 - x2
        OP_MUL_LY,    // t = lam*(x1-x3)
        OP_Y3,        // y3 = t - y1
        OP_COMMIT,    // write result to acc or base
        OP_INF,       // write identity to target
        OP_PASS,      // one operand is identity
        OP_SHIFT,     // k >>= 1
        OP_DIV        // record divisor
    } t_op;

    typedef struct packed {
        t_op  op;
        logic to_acc;
    } t_cmd;

    typedef struct packed {
        logic busy;     // multi-cycle unit still running
        logic k_zero;
        logic k_lsb;
        logic n_small;
        logic p_inf;
        logic q_inf;
        logic g_one;
        logic g_n;
    } t_sts;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_RX, S_RY, S_RA, S_WRED, S_CHECK, S_SETUP, S_OPEN,
        S_GDX, S_GSY, S_GWAIT, S_GEVAL, S_NUM, S_XX, S_TAN, S_LL, S_X3,
        S_LY, S_Y3, S_COMMIT, S_MWAIT, S_NEXT, S_OUT
    } t_state;

endpackage

@@ sv/ecm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ECM controller
// Sequences reductions, double-and-add over the scalar and point operations.
// ----------------------------------------------------------------------------
module ecm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_out_free,
    input  ecm_pkg::t_sts i_sts,
    output ecm_pkg::t_cmd o_cmd,
    output logic          o_done,
    output logic          o_busy
);

    ecm_pkg::t_state r_state, n_state;
    ecm_pkg::t_state r_ret, n_ret;
    logic            r_dbl, n_dbl;     // current operation is a doubling
    logic            r_sy, n_sy;       // gcd on y1+y2 phase

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecm_pkg::S_IDLE;
            r_ret   <= ecm_pkg::S_IDLE;
            r_dbl   <= 1'b0;
            r_sy    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_dbl   <= n_dbl;
            r_sy    <= n_sy;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_dbl   = r_dbl;
        n_sy    = r_sy;
        unique case (r_state)
            ecm_pkg::S_IDLE:  if (i_start) n_state = ecm_pkg::S_LOAD;
            ecm_pkg::S_LOAD: begin
                if (i_sts.n_small) n_state = ecm_pkg::S_OUT;
                else               n_state = ecm_pkg::S_RX;
            end
            ecm_pkg::S_RX: begin
                n_ret = ecm_pkg::S_RY; n_state = ecm_pkg::S_WRED;
            end
            ecm_pkg::S_RY: begin
                n_ret = ecm_pkg::S_RA; n_state = ecm_pkg::S_WRED;
            end
            ecm_pkg::S_RA: begin
                n_ret = ecm_pkg::S_CHECK; n_state = ecm_pkg::S_WRED;
            end
            ecm_pkg::S_WRED:  if (!i_sts.busy) n_state = r_ret;
            ecm_pkg::S_CHECK: begin
                if (i_sts.k_zero) n_state = ecm_pkg::S_OUT;
                else begin
                    n_dbl   = !i_sts.k_lsb;
                    n_state = ecm_pkg::S_SETUP;
                end
            end
            ecm_pkg::S_SETUP: n_state = ecm_pkg::S_OPEN;
            ecm_pkg::S_OPEN: begin
                n_sy = 1'b0;
                if (i_sts.p_inf || i_sts.q_inf) n_state = ecm_pkg::S_NEXT;
                else                            n_state = ecm_pkg::S_GDX;
            end
            ecm_pkg::S_GDX:   n_state = ecm_pkg::S_GWAIT;
            ecm_pkg::S_GSY:   n_state = ecm_pkg::S_GWAIT;
            ecm_pkg::S_GWAIT: if (!i_sts.busy) n_state = ecm_pkg::S_GEVAL;
            ecm_pkg::S_GEVAL: begin
                if (!i_sts.g_one && !i_sts.g_n)     n_state = ecm_pkg::S_OUT;
                else if (i_sts.g_one && !r_sy)      n_state = ecm_pkg::S_NUM;
                else if (i_sts.g_one)               n_state = ecm_pkg::S_XX;
                else if (!r_sy) begin
                    n_sy = 1'b1; n_state = ecm_pkg::S_GSY;
                end else                            n_state = ecm_pkg::S_NEXT;
            end
            ecm_pkg::S_NUM: begin
                n_ret = ecm_pkg::S_LL; n_state = ecm_pkg::S_MWAIT;
            end
            ecm_pkg::S_XX: begin
                n_ret = ecm_pkg::S_TAN; n_state = ecm_pkg::S_MWAIT;
            end
            ecm_pkg::S_TAN: begin
                n_ret = ecm_pkg::S_LL; n_state = ecm_pkg::S_MWAIT;
            end
            ecm_pkg::S_LL: begin
                n_ret = ecm_pkg::S_X3; n_state = ecm_pkg::S_MWAIT;
            end
            ecm_pkg::S_X3:    n_state = ecm_pkg::S_LY;
            ecm_pkg::S_LY: begin
                n_ret = ecm_pkg::S_Y3; n_state = ecm_pkg::S_MWAIT;
            end
            ecm_pkg::S_Y3:    n_state = ecm_pkg::S_COMMIT;
            ecm_pkg::S_COMMIT: n_state = ecm_pkg::S_NEXT;
            ecm_pkg::S_MWAIT: if (!i_sts.busy) n_state = r_ret;
            ecm_pkg::S_NEXT: begin
                if (!r_dbl) begin
                    n_dbl = 1'b1; n_state = ecm_pkg::S_SETUP;
                end else n_state = ecm_pkg::S_CHECK;
            end
            ecm_pkg::S_OUT:   if (i_out_free) n_state = ecm_pkg::S_IDLE;
            default:          n_state = ecm_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd.op     = ecm_pkg::OP_NONE;
        o_cmd.to_acc = !r_dbl;
        o_done       = 1'b0;
        o_busy       = 1'b1;
        unique case (r_state)
            ecm_pkg::S_IDLE:  o_busy = 1'b0;
            ecm_pkg::S_LOAD:  o_cmd.op = ecm_pkg::OP_LOAD;
            ecm_pkg::S_RX:    o_cmd.op = ecm_pkg::OP_RED_X;
            ecm_pkg::S_RY:    o_cmd.op = ecm_pkg::OP_RED_Y;
            ecm_pkg::S_RA:    o_cmd.op = ecm_pkg::OP_RED_A;
            ecm_pkg::S_SETUP: o_cmd.op = r_dbl ? ecm_pkg::OP_SETUP_DBL
                                               : ecm_pkg::OP_SETUP_ADD;
            ecm_pkg::S_OPEN: begin
                if (i_sts.p_inf || i_sts.q_inf) o_cmd.op = ecm_pkg::OP_PASS;
            end
            ecm_pkg::S_GDX:   o_cmd.op = ecm_pkg::OP_GCD_DX;
            ecm_pkg::S_GSY:   o_cmd.op = ecm_pkg::OP_GCD_SY;
            ecm_pkg::S_GWAIT: o_cmd.op = ecm_pkg::OP_GCD_STEP;
            ecm_pkg::S_GEVAL: begin
                if (!i_sts.g_one && !i_sts.g_n)        o_cmd.op = ecm_pkg::OP_DIV;
                else if (!i_sts.g_one && r_sy)         o_cmd.op = ecm_pkg::OP_INF;
            end
            ecm_pkg::S_NUM:   o_cmd.op = ecm_pkg::OP_MUL_NUM;
            ecm_pkg::S_XX:    o_cmd.op = ecm_pkg::OP_MUL_XX;
            ecm_pkg::S_TAN:   o_cmd.op = ecm_pkg::OP_MUL_TAN;
            ecm_pkg::S_LL:    o_cmd.op = ecm_pkg::OP_MUL_LL;
            ecm_pkg::S_X3:    o_cmd.op = ecm_pkg::OP_X3;
            ecm_pkg::S_LY:    o_cmd.op = ecm_pkg::OP_MUL_LY;
            ecm_pkg::S_Y3:    o_cmd.op = ecm_pkg::OP_Y3;
            ecm_pkg::S_COMMIT: o_cmd.op = ecm_pkg::OP_COMMIT;
            ecm_pkg::S_NEXT:  if (r_dbl) o_cmd.op = ecm_pkg::OP_SHIFT;
            ecm_pkg::S_OUT:   o_done = 1'b1;
            default:          o_cmd.op = ecm_pkg::OP_NONE;
        endcase
    end

endmodule

@@ sv/ecm_dpath.sv @@
// ----------------------------------------------------------------------------
// ECM datapath
// Point registers, a bit-serial modular multiplier/reducer and an
// iterative extended Euclid with bit-serial division.
// ----------------------------------------------------------------------------
module ecm_dpath #(
    parameter int unsigned WIDTH = ecm_pkg::WidthDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ecm_pkg::t_cmd    i_cmd,
    input  logic [WIDTH-1:0] i_modulus,
    input  logic [WIDTH-1:0] i_curve_a,
    input  logic [WIDTH-1:0] i_px,
    input  logic [WIDTH-1:0] i_py,
    input  logic             i_pinf,
    input  logic [WIDTH-1:0] i_k,
    output ecm_pkg::t_sts    o_sts,
    output logic [WIDTH-1:0] o_rx,
    output logic [WIDTH-1:0] o_ry,
    output logic             o_rinf,
    output logic [WIDTH-1:0] o_div
);

    localparam int unsigned CntW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_n, r_a, r_k, r_div;
    logic [WIDTH-1:0] r_ax, r_ay, r_bx, r_by;
    logic             r_ainf, r_binf;
    logic [WIDTH-1:0] r_x1, r_y1, r_x2, r_y2, r_lam, r_t, r_x3, r_y3;
    logic             r_pinf, r_qinf;

    // Multiplier / reducer: r = r*2 + bit*a mod n, MSB first.
    logic [WIDTH-1:0] r_ma, r_mb, r_mr;
    logic [CntW-1:0]  r_mcnt;
    logic             r_mbusy;
    logic [1:0]       r_mdst;            // 0:lam 1:t 2:reduce target 3:none
    logic [1:0]       r_rsel;            // reduce target select

    // Euclid: r0,r1,t0,t1; division q = r0/r1 bit-serial, then q*t1 mod n.
    logic [WIDTH-1:0] r_r0, r_r1, r_t0, r_t1, r_q, r_rem;
    logic [CntW-1:0]  r_gcnt;
    logic [1:0]       r_gph;             // 0 test 1 divide 2 start multiply 3 multiply
    logic             r_gbusy;

    // Modular helpers.
    function automatic logic [WIDTH-1:0] f_add(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] n);
        logic [WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, n}) s = s - {1'b0, n};
        return s[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] f_sub(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] n);
        return (a >= b) ? (a - b) : (n - (b - a));
    endfunction

    logic [WIDTH-1:0] w_dbl, w_mstep, w_mnext;
    logic [WIDTH:0]   w_rtry;
    logic [WIDTH-1:0] w_rsh;
    always_comb begin
        w_dbl   = f_add(r_mr, r_mr, r_n);
        w_mstep = f_add(w_dbl, r_ma, r_n);
        w_mnext = r_mb[WIDTH-1] ? w_mstep : w_dbl;
        // restoring division step
        w_rsh   = {r_rem[WIDTH-2:0], r_r0[WIDTH-1]};
        w_rtry  = {r_rem, r_r0[WIDTH-1]} - {1'b0, r_r1};
    end

    logic [WIDTH-1:0] w_3t;
    assign w_3t = f_add(f_add(r_t, r_t, r_n), r_t, r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_gbusy <= 1'b0;
            r_gph   <= '0;
        end else begin
            // multiplier / reducer iteration
            if (r_mbusy) begin
                r_mr   <= w_mnext;
                r_mb   <= {r_mb[WIDTH-2:0], 1'b0};
                r_mcnt <= r_mcnt - 1'b1;
                if (r_mcnt == CntW'(1)) begin
                    r_mbusy <= 1'b0;
                    case (r_mdst)
                        2'd0: r_lam <= w_mnext;
                        2'd1: r_t   <= w_mnext;
                        2'd2: begin
                            case (r_rsel)
                                2'd0:    r_bx <= w_mnext;
                                2'd1:    r_by <= w_mnext;
                                default: r_a  <= w_mnext;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            // Euclid iteration
            if (r_gbusy) begin
                case (r_gph)
                    2'd0: begin
                        if (r_r1 == '0) r_gbusy <= 1'b0;
                        else begin
                            r_gph  <= 2'd1;
                            r_rem  <= '0;
                            r_q    <= '0;
                            r_gcnt <= CntW'(WIDTH);
                        end
                    end
                    2'd1: begin
                        // quotient builds in r_q; dividend bits shift from r_r0
                        r_r0 <= {r_r0[WIDTH-2:0], 1'b0};
                        if (!w_rtry[WIDTH]) begin
                            r_rem <= w_rtry[WIDTH-1:0];
                            r_q   <= {r_q[WIDTH-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_q   <= {r_q[WIDTH-2:0], 1'b0};
                        end
                        r_gcnt <= r_gcnt - 1'b1;
                        if (r_gcnt == CntW'(1)) r_gph <= 2'd2;
                    end
                    2'd2: begin
                        // start q mod n times t1 on the multiplier
                        r_mbusy <= 1'b1;
                        r_mcnt  <= CntW'(WIDTH);
                        r_mr    <= '0;
                        r_ma    <= r_t1;
                        r_mb    <= (r_q >= r_n) ? r_q - r_n : r_q;
                        r_mdst  <= 2'd3;
                        r_gph   <= 2'd3;
                    end
                    default: begin
                        if (!r_mbusy) begin
                            r_t0  <= r_t1;
                            r_t1  <= f_sub(r_t0, r_mr, r_n);
                            r_r0  <= r_r1;
                            r_r1  <= r_rem;
                            r_gph <= 2'd0;
                        end
                    end
                endcase
            end
            // commands
            case (i_cmd.op)
                ecm_pkg::OP_LOAD: begin
                    r_n    <= i_modulus;
                    r_a    <= i_curve_a;
                    r_bx   <= i_px;
                    r_by   <= i_py;
                    r_binf <= i_pinf;
                    r_k    <= i_k;
                    r_ainf <= 1'b1;
                    r_ax   <= '0;
                    r_ay   <= '0;
                    r_div  <= '0;
                end
                ecm_pkg::OP_RED_X, ecm_pkg::OP_RED_Y, ecm_pkg::OP_RED_A: begin
                    r_mbusy <= 1'b1;
                    r_mcnt  <= CntW'(WIDTH);
                    r_mr    <= '0;
                    r_ma    <= WIDTH'(1);
                    r_mdst  <= 2'd2;
                    if (i_cmd.op == ecm_pkg::OP_RED_X) begin
                        r_mb <= r_bx; r_rsel <= 2'd0;
                    end else if (i_cmd.op == ecm_pkg::OP_RED_Y) begin
                        r_mb <= r_by; r_rsel <= 2'd1;
                    end else begin
                        r_mb <= r_a;  r_rsel <= 2'd2;
                    end
                end
                ecm_pkg::OP_SETUP_ADD: begin
                    r_x1 <= r_ax; r_y1 <= r_ay; r_pinf <= r_ainf;
                    r_x2 <= r_bx; r_y2 <= r_by; r_qinf <= r_binf;
                end
                ecm_pkg::OP_SETUP_DBL: begin
                    r_x1 <= r_bx; r_y1 <= r_by; r_pinf <= r_binf;
                    r_x2 <= r_bx; r_y2 <= r_by; r_qinf <= r_binf;
                end
                ecm_pkg::OP_GCD_DX, ecm_pkg::OP_GCD_SY: begin
                    r_gbusy <= 1'b1;
                    r_gph   <= 2'd0;
                    r_r0    <= r_n;
                    r_r1    <= (i_cmd.op == ecm_pkg::OP_GCD_DX) ?
                               f_sub(r_x1, r_x2, r_n) : f_add(r_y1, r_y2, r_n);
                    r_t0    <= '0;
                    r_t1    <= WIDTH'(1);
                end
                ecm_pkg::OP_MUL_NUM, ecm_pkg::OP_MUL_XX, ecm_pkg::OP_MUL_TAN,
                ecm_pkg::OP_MUL_LL, ecm_pkg::OP_MUL_LY: begin
                    r_mbusy <= 1'b1;
                    r_mcnt  <= CntW'(WIDTH);
                    r_mr    <= '0;
                    case (i_cmd.op)
                        ecm_pkg::OP_MUL_NUM: begin
                            r_ma <= f_sub(r_y1, r_y2, r_n); r_mb <= r_t0; r_mdst <= 2'd0;
                        end
                        ecm_pkg::OP_MUL_XX: begin
                            r_ma <= r_x1; r_mb <= r_x1; r_mdst <= 2'd1;
                        end
                        ecm_pkg::OP_MUL_TAN: begin
                            r_ma <= f_add(w_3t, r_a, r_n); r_mb <= r_t0; r_mdst <= 2'd0;
                        end
                        ecm_pkg::OP_MUL_LL: begin
                            r_ma <= r_lam; r_mb <= r_lam; r_mdst <= 2'd1;
                        end
                        default: begin
                            r_ma <= r_lam; r_mb <= f_sub(r_x1, r_x3, r_n);
                            r_mdst <= 2'd1;
                        end
                    endcase
                end
                ecm_pkg::OP_X3: r_x3 <= f_sub(f_sub(r_t, r_x1, r_n), r_x2, r_n);
                ecm_pkg::OP_Y3: r_y3 <= f_sub(r_t, r_y1, r_n);
                ecm_pkg::OP_COMMIT: begin
                    if (i_cmd.to_acc) begin
                        r_ax <= r_x3; r_ay <= r_y3; r_ainf <= 1'b0;
                    end else begin
                        r_bx <= r_x3; r_by <= r_y3; r_binf <= 1'b0;
                    end
                end
                ecm_pkg::OP_INF: begin
                    if (i_cmd.to_acc) begin
                        r_ax <= '0; r_ay <= '0; r_ainf <= 1'b1;
                    end else begin
                        r_bx <= '0; r_by <= '0; r_binf <= 1'b1;
                    end
                end
                ecm_pkg::OP_PASS: begin
                    // identity plus Q is Q, P plus identity is P
                    if (i_cmd.to_acc && r_pinf) begin
                        r_ax <= r_x2; r_ay <= r_y2; r_ainf <= r_qinf;
                    end else if (!i_cmd.to_acc && r_pinf) begin
                        r_bx <= r_x2; r_by <= r_y2; r_binf <= r_qinf;
                    end
                end
                ecm_pkg::OP_SHIFT: r_k   <= r_k >> 1;
                ecm_pkg::OP_DIV:   r_div <= r_r0;
                default: ;
            endcase
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.busy    = r_mbusy || r_gbusy;
        o_sts.k_zero  = (r_k == '0);
        o_sts.k_lsb   = r_k[0];
        o_sts.n_small = (i_modulus < WIDTH'(2));
        o_sts.p_inf   = r_pinf;
        o_sts.q_inf   = r_qinf;
        o_sts.g_one   = (r_r0 == WIDTH'(1));
        o_sts.g_n     = (r_r0 == r_n);
    end

    assign o_rx   = r_ainf ? '0 : r_ax;
    assign o_ry   = r_ainf ? '0 : r_ay;
    assign o_rinf = r_ainf;
    assign o_div  = r_div;

endmodule

@@ sv/ecm_point_scalar_multiply_unit.sv @@
// ----------------------------------------------------------------------------
// ECM point scalar multiply unit
// Work: per scalar bit up to two point operations, each up to two Euclid
// runs of up to about 1.5*WIDTH steps, each step a bit-serial division and
// a bit-serial multiply, plus up to four bit-serial multiplications; if
// n < 2 the controller goes straight to its output state.
// Throughput: one item at a time, bounded by the shared bit-serial units.
// Reset: synchronous, active low; modulus resets to 2, curve_a to 0.
// ----------------------------------------------------------------------------
module ecm_point_scalar_multiply_unit #(
    parameter int unsigned WIDTH = ecm_pkg::WidthDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ecm_pkg::RegIdxW-1:0] i_cfg_idx,
    input  logic [WIDTH-1:0]            i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // point_x, point_y, scalar from bit 0 up
    input  logic [3*WIDTH-1:0]          s_axis_tdata,
    // point_at_infinity
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // result_x, result_y, divisor from bit 0 up
    output logic [3*WIDTH-1:0]          m_axis_tdata,
    // result_at_infinity
    output logic                        m_axis_tuser
);

    logic [WIDTH-1:0] r_modulus, r_curve_a;
    logic [3*WIDTH-1:0] r_in;
    logic               r_in_inf;
    logic               r_ovalid;
    logic [3*WIDTH-1:0] r_odata;
    logic               r_ouser;

    ecm_pkg::t_cmd w_cmd;
    ecm_pkg::t_sts w_sts;
    logic          w_done, w_busy, w_start;
    logic [WIDTH-1:0] w_rx, w_ry, w_div;
    logic          w_rinf;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WIDTH'(2);
            r_curve_a <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ecm_pkg::RegModulus: r_modulus <= i_cfg_data;
                ecm_pkg::RegCurveA:  r_curve_a <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_busy;
    assign w_start       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_in     <= s_axis_tdata;
            r_in_inf <= s_axis_tuser;
        end
    end

    // Output register; the controller waits in its output state while full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (w_done && !r_ovalid) begin
                r_ovalid <= 1'b1;
                r_odata  <= {w_div, w_ry, w_rx};
                r_ouser  <= w_rinf;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    ecm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (!r_ovalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_done     (w_done),
        .o_busy     (w_busy)
    );

    ecm_dpath #(.WIDTH(WIDTH)) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_modulus (r_modulus),
        .i_curve_a (r_curve_a),
        .i_px      (r_in[WIDTH-1:0]),
        .i_py      (r_in[2*WIDTH-1:WIDTH]),
        .i_pinf    (r_in_inf),
        .i_k       (r_in[3*WIDTH-1:2*WIDTH]),
        .o_sts     (w_sts),
        .o_rx      (w_rx),
        .o_ry      (w_ry),
        .o_rinf    (w_rinf),
        .o_div     (w_div)
    );

endmodule

@@ verif/ecm_checker.sv @@
// ----------------------------------------------------------------------------
// ECM scalar multiply checker
// Watches the register port and both streams, predicts each product from its
// own copy of the curve settings and compares every result transfer with it.
// ----------------------------------------------------------------------------
module ecm_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [191:0] i_in_data,
    input  logic         i_in_user,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [191:0] i_out_data,
    input  logic         i_out_user,
    output int           o_pending,
    output int           o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] x;
        logic [63:0] y;
        logic        inf;
    } t_curve_pt;

    typedef struct {
        logic [63:0] rx;
        logic [63:0] ry;
        logic        rinf;
        logic [63:0] div;
    } t_product;

    logic [63:0] modulus_q;
    logic [63:0] curve_a_q;
    t_product    product_q[$];

    function automatic logic [63:0] mod_add(input logic [63:0] a, b, n);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, n}) s = s - {1'b0, n};
        return s[63:0];
    endfunction

    function automatic logic [63:0] mod_sub(input logic [63:0] a, b, n);
        return (a >= b) ? a - b : n - (b - a);
    endfunction

    function automatic logic [63:0] mod_mul(input logic [63:0] a, b, n);
        logic [63:0] r;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = mod_add(r, r, n);
            if (b[i]) r = mod_add(r, a, n);
        end
        return r;
    endfunction

    // Extended Euclid: returns gcd(v, n), inv gets t with t*v == gcd mod n.
    function automatic logic [63:0] euclid_inv(input logic [63:0] v, n,
                                               output logic [63:0] inv);
        logic [63:0] r0, r1, r2, t0, t1, t2, q;
        r0 = n;
        r1 = v;
        t0 = '0;
        t1 = 64'd1;
        while (r1 != 0) begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            t2 = mod_sub(t0, mod_mul(q % n, t1, n), n);
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        inv = t0;
        return r0;
    endfunction

    // Pseudo-addition; returns a factor strictly between 1 and n, else 0.
    function automatic logic [63:0] point_sum(output t_curve_pt r, input t_curve_pt p, q,
                                              input logic [63:0] a, n);
        logic [63:0] inv, g, lam, t, x3;
        if (p.inf) begin
            r = q;
            return 0;
        end
        if (q.inf) begin
            r = p;
            return 0;
        end
        g = euclid_inv(mod_sub(p.x, q.x, n), n, inv);
        r = p;
        if (g > 1 && g < n) return g;
        if (g == 1) begin
            lam = mod_mul(mod_sub(p.y, q.y, n), inv, n);
        end else begin
            g = euclid_inv(mod_add(p.y, q.y, n), n, inv);
            if (g > 1 && g < n) return g;
            if (g == n) begin
                r.x = '0;
                r.y = '0;
                r.inf = 1'b1;
                return 0;
            end
            t   = mod_mul(p.x, p.x, n);
            t   = mod_add(mod_add(t, t, n), t, n);
            lam = mod_mul(mod_add(t, a, n), inv, n);
        end
        x3 = mod_sub(mod_sub(mod_mul(lam, lam, n), p.x, n), q.x, n);
        r.y = mod_sub(mod_mul(lam, mod_sub(p.x, x3, n), n), p.y, n);
        r.x = x3;
        r.inf = 1'b0;
        return 0;
    endfunction

    // Scalar multiplication, least significant bit first.
    function automatic t_product scalar_product(input logic [191:0] data, input logic inf);
        t_curve_pt   acc, base;
        logic [63:0] k, d, a, n;
        t_product    res;
        n = modulus_q;
        d = '0;
        acc.x = '0;
        acc.y = '0;
        acc.inf = 1'b1;
        if (n >= 2) begin
            a = curve_a_q % n;
            base.x = data[63:0] % n;
            base.y = data[127:64] % n;
            base.inf = inf;
            k = data[191:128];
            while (k != 0) begin
                if (k[0]) begin
                    d = point_sum(acc, acc, base, a, n);
                    if (d != 0) break;
                end
                d = point_sum(base, base, base, a, n);
                if (d != 0) break;
                k = k >> 1;
            end
        end
        res.rx = acc.inf ? '0 : acc.x;
        res.ry = acc.inf ? '0 : acc.y;
        res.rinf = acc.inf;
        res.div = d;
        return res;
    endfunction

    assign o_pending = product_q.size();

    // Track settings, queue predictions and compare result transfers.
    always @(posedge i_clk) begin
        t_product exp_p;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            modulus_q <= 64'd2;
            curve_a_q <= '0;
            product_q.delete();
            o_errors  <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == ecm_pkg::RegModulus) modulus_q <= i_cfg_data;
                else if (i_cfg_idx == ecm_pkg::RegCurveA) curve_a_q <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                product_q = {product_q, scalar_product(i_in_data, i_in_user)};
            if (i_out_valid && i_out_ready) begin
                if (product_q.size() == 0) begin
                    $error("result transfer with no product expected");
                    errs++;
                end else begin
                    exp_p = product_q.pop_front();
                    if (i_out_data[63:0] !== exp_p.rx) begin
                        $error("result_x expected %0h actual %0h", exp_p.rx, i_out_data[63:0]);
                        errs++;
                    end
                    if (i_out_data[127:64] !== exp_p.ry) begin
                        $error("result_y expected %0h actual %0h", exp_p.ry,
                               i_out_data[127:64]);
                        errs++;
                    end
                    if (i_out_user !== exp_p.rinf) begin
                        $error("result_at_infinity expected %0b actual %0b", exp_p.rinf,
                               i_out_user);
                        errs++;
                    end
                    if (i_out_data[191:128] !== exp_p.div) begin
                        $error("divisor expected %0h actual %0h", exp_p.div,
                               i_out_data[191:128]);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// ECM scalar multiply testbench
// Drives directed and random points and scalars through several curve and
// modulus settings with random stalls on both streams; a checker predicts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [0:0]   i_cfg_idx = ecm_pkg::RegModulus;
    logic [63:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         steady = 1'b0;
    logic [63:0]  modulus_now = 64'd2;
    int           pending;
    int           errors;

    ecm_point_scalar_multiply_unit #(.WIDTH(64)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    ecm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .o_pending(pending), .o_errors(errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stalls at random unless a steady stretch is running.
    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready = steady || ($urandom_range(0, 99) >= 24);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // One input transfer, with an optional random gap before it.
    task automatic send_point(input logic [63:0] x, y, input logic inf,
                              input logic [63:0] k);
        if (!steady && $urandom_range(0, 99) < 24) repeat ($urandom_range(1, 4)) @(negedge i_clk);
        s_axis_tdata  = {k, y, x};
        s_axis_tuser  = inf;
        s_axis_tvalid = 1'b1;
        #1;
        while (!s_axis_tready) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Registers change only once the block has drained.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [63:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == ecm_pkg::RegModulus) modulus_now = value;
    endtask

    task automatic random_point();
        logic [63:0] x, y, k;
        x = rand64();
        y = rand64();
        if (modulus_now >= 2 && $urandom_range(0, 1) == 1) begin
            x = x % modulus_now;
            y = y % modulus_now;
        end
        // Wide scalars only where every point operation is short.
        if ((modulus_now < 2 || modulus_now <= 221) && $urandom_range(0, 9) == 0)
            k = rand64();
        else
            k = 64'($urandom_range(1, 300));
        send_point(x, y, ($urandom_range(0, 7) == 0), k);
    endtask

    initial begin
        logic [63:0] moduli[4];
        logic [63:0] coeffs[4];
        moduli = '{64'd1000036000099, '1, 64'd0, 64'd95};
        coeffs = '{64'd5, 64'd3, 64'd7, 64'd0};
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: smallest modulus.
        send_point('1, '1, 1'b0, '1);
        send_point(64'd1, 64'd0, 1'b0, 64'd3);
        send_point('0, '0, 1'b0, '0);
        drain();

        // Small composite with an unreduced coefficient.
        write_reg(ecm_pkg::RegModulus, 64'd221);
        write_reg(ecm_pkg::RegCurveA, '1);
        send_point(64'd5, 64'd7, 1'b0, '0);
        send_point(64'd5, 64'd7, 1'b0, 64'd1);
        send_point(64'd5, 64'd7, 1'b1, 64'd5);
        send_point('1, '1, 1'b0, 64'd3);
        send_point(64'd2, 64'd3, 1'b0, '1);
        send_point(64'd9, 64'd0, 1'b0, 64'd2);
        send_point(64'd1, 64'd13, 1'b0, 64'd2);
        send_point(64'd100, 64'd200, 1'b0, 64'h8000_0000_0000_0000);
        repeat (10) random_point();
        // Hold the sender until the block is empty.
        while (pending != 0) @(negedge i_clk);
        repeat (8) random_point();

        for (int p = 0; p < 4; p++) begin
            drain();
            write_reg(ecm_pkg::RegModulus, moduli[p]);
            write_reg(ecm_pkg::RegCurveA, coeffs[p]);
            steady = (p == 3);
            repeat (18) random_point();
        end
        steady = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #500_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ecm_pkg.sv
sv/ecm_ctrl.sv
sv/ecm_dpath.sv
sv/ecm_point_scalar_multiply_unit.sv
verif/ecm_checker.sv
verif/testbench.sv
